### rtl/crc_checked_frame_decoder_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the framed message decoder
// Shared shorthands for concurrent checks on the block's ports.
// ----------------------------------------------------------------------------
`ifndef CRC_CHECKED_FRAME_DECODER_TOP_DEFINES_SVH
`define CRC_CHECKED_FRAME_DECODER_TOP_DEFINES_SVH

// Check that a condition implies another in the same cycle.
`define CCFD_ASSERT_IMPLY(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("decoder check failed: same-cycle implication");

// Check that a condition implies another in the next cycle.
`define CCFD_ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("decoder check failed: next-cycle implication");

`endif

### rtl/ccfd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Framed message decoder package
// Types, frame layout constants and the CRC-32 byte step.
// ----------------------------------------------------------------------------
package ccfd_pkg;

    localparam int OUT_DATA_W = 64;

    localparam logic [8:0]  POS_VERSION     = 9'd4;
    localparam logic [8:0]  POS_ID_FIRST    = 9'd5;
    localparam logic [8:0]  POS_LEN_LO      = 9'd9;
    localparam logic [8:0]  POS_LEN_HI      = 9'd10;
    localparam logic [8:0]  HEADER_BYTES    = 9'd11;
    localparam logic [16:0] MIN_FRAME_BYTES = 17'd15;
    localparam logic [8:0]  COUNT_MAX       = 9'd511;
    localparam logic [8:0]  EMIT_LIMIT      = 9'd255;

    localparam logic [31:0] MAGIC_WORD    = 32'h5042_3358;
    localparam logic [7:0]  FRAME_VERSION = 8'h01;
    localparam logic [31:0] CRC_POLY      = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT      = 32'hFFFF_FFFF;

    localparam logic [20:0] CP_MAX        = 21'h10_FFFF;
    localparam logic [20:0] CP_SURR_LO    = 21'h00_D800;
    localparam logic [20:0] CP_SURR_HI    = 21'h00_DFFF;
    localparam logic [20:0] CP_MIN_TWO    = 21'h00_0080;
    localparam logic [20:0] CP_MIN_THREE  = 21'h00_0800;
    localparam logic [20:0] CP_MIN_FOUR   = 21'h01_0000;
    localparam logic [7:0]  LEAD_ASCII_MAX = 8'h7F;
    localparam logic [7:0]  LEAD_TWO_MIN   = 8'hC2;
    localparam logic [7:0]  LEAD_TWO_MAX   = 8'hDF;
    localparam logic [7:0]  LEAD_THREE_MIN = 8'hE0;
    localparam logic [7:0]  LEAD_THREE_MAX = 8'hEF;
    localparam logic [7:0]  LEAD_FOUR_MIN  = 8'hF0;
    localparam logic [7:0]  LEAD_FOUR_MAX  = 8'hF4;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    typedef enum logic [2:0] {
        CLS_MAGIC,
        CLS_VERSION,
        CLS_ID,
        CLS_LEN_LO,
        CLS_LEN_HI,
        CLS_PAYLOAD,
        CLS_TRAILER
    } ccfd_class_t;

    typedef enum logic [2:0] {
        ST_ACCEPTED    = 3'd0,
        ST_BAD_MAGIC   = 3'd1,
        ST_BAD_VERSION = 3'd2,
        ST_BAD_LENGTH  = 3'd3,
        ST_BAD_CRC     = 3'd4
    } ccfd_status_t;

    typedef struct packed {
        logic [7:0]  data;
        logic        last;
        ccfd_class_t cls;
        logic [1:0]  sub;
        logic        emit;
        logic [7:0]  pidx;
        logic [15:0] decl;
        logic [8:0]  total;
    } ccfd_item_t;

    typedef struct packed {
        logic [1:0]  pending;
        logic [20:0] acc;
        logic [1:0]  min_class;
        logic        bad;
    } ccfd_utf8_t;

    function automatic logic [31:0] crc32_byte(input logic [31:0] crc_in,
                                               input logic [7:0]  b);
        logic [31:0] c;
        c = crc_in ^ {24'h000000, b};
        for (int k = 0; k < 8; k++) begin
            c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
        end
        return c;
    endfunction

endpackage

### rtl/ccfd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Decoder front end
// Tracks frame position and declared length, tags each byte with its role.
// ----------------------------------------------------------------------------
module ccfd_front import ccfd_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,
    input  logic        s_axis_tlast,
    output logic        push_valid,
    input  logic        push_ready,
    output ccfd_item_t  push_item
);

    logic [8:0]  count_reg, count_next, count_inc, pay_idx;
    logic [15:0] decl_reg, decl_next;
    logic        push;

    assign push          = s_axis_tvalid && push_ready;
    assign s_axis_tready = push_ready;
    assign push_valid    = s_axis_tvalid;
    assign pay_idx       = count_reg - HEADER_BYTES;
    assign count_inc     = (count_reg < COUNT_MAX) ? count_reg + 9'd1 : COUNT_MAX;

    always_comb begin
        decl_next      = decl_reg;
        push_item      = '0;
        push_item.data = s_axis_tdata;
        push_item.last = s_axis_tlast;
        push_item.cls  = CLS_TRAILER;
        if (count_reg < POS_VERSION) begin
            push_item.cls = CLS_MAGIC;
            push_item.sub = count_reg[1:0];
        end else if (count_reg == POS_VERSION) begin
            push_item.cls = CLS_VERSION;
        end else if (count_reg < POS_LEN_LO) begin
            push_item.cls = CLS_ID;
            push_item.sub = 2'(count_reg - POS_ID_FIRST);
        end else if (count_reg == POS_LEN_LO) begin
            push_item.cls = CLS_LEN_LO;
            decl_next     = {8'h00, s_axis_tdata};
        end else if (count_reg == POS_LEN_HI) begin
            push_item.cls = CLS_LEN_HI;
            decl_next     = {s_axis_tdata, decl_reg[7:0]};
        end else if ({7'h00, pay_idx} < decl_reg) begin
            push_item.cls  = CLS_PAYLOAD;
            push_item.emit = (pay_idx < EMIT_LIMIT);
            push_item.pidx = pay_idx[7:0];
        end
        push_item.decl  = decl_next;
        push_item.total = count_inc;
    end

    always_comb begin
        count_next = count_reg;
        if (push) begin
            count_next = s_axis_tlast ? 9'd0 : count_inc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            decl_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                decl_reg <= s_axis_tlast ? 16'h0000 : decl_next;
            end
        end
    end

endmodule

### rtl/ccfd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Decoder item queue
// Small first-in first-out buffer between the front and back ends.
// ----------------------------------------------------------------------------
module ccfd_queue import ccfd_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push_valid,
    output logic       push_ready,
    input  ccfd_item_t push_item,
    output logic       pop_valid,
    input  logic       pop_ready,
    output ccfd_item_t pop_item
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    ccfd_item_t       mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             push, pop;

    assign push_ready = (count_reg != CNT_FULL);
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = mem_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

### rtl/ccfd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Decoder back end
// Runs header checks, CRC-32 and UTF-8 validation; drives the result beat.
// ----------------------------------------------------------------------------
module ccfd_back import ccfd_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [7:0]            max_len,
    input  logic                  item_valid,
    output logic                  item_pop,
    input  ccfd_item_t            item,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    output logic                  m_axis_tuser
);

    logic                  magic_ok_reg, magic_ok_next;
    logic                  version_ok_reg, version_ok_next;
    logic [31:0]           id_reg, id_next;
    logic [31:0]           crc_reg, crc_next;
    logic [31:0]           rx_crc_reg, rx_crc_next;
    ccfd_utf8_t            utf_reg, utf_next;
    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg, out_data_next;
    logic                  out_kind_reg, out_kind_next;
    logic                  slot_free, produce;
    logic [20:0]           acc_sh, cp_min;
    logic                  len_bad, crc_bad, has_id;
    ccfd_status_t          status;
    logic [7:0]            b;

    assign b         = item.data;
    assign slot_free = !out_valid_reg || m_axis_tready;
    assign item_pop  = item_valid && slot_free;
    assign produce   = item.last || item.emit;
    assign acc_sh    = {utf_reg.acc[14:0], b[5:0]};

    always_comb begin
        case (utf_reg.min_class)
            2'd0:    cp_min = CP_MIN_TWO;
            2'd1:    cp_min = CP_MIN_THREE;
            default: cp_min = CP_MIN_FOUR;
        endcase
    end

    // Per-byte state update
    always_comb begin
        magic_ok_next   = magic_ok_reg;
        version_ok_next = version_ok_reg;
        id_next         = id_reg;
        crc_next        = crc_reg;
        rx_crc_next     = rx_crc_reg;
        utf_next        = utf_reg;
        case (item.cls)
            CLS_MAGIC: begin
                if (b != MAGIC_WORD[8*item.sub +: 8]) magic_ok_next = 1'b0;
            end
            CLS_VERSION: begin
                if (b != FRAME_VERSION) version_ok_next = 1'b0;
            end
            CLS_ID: begin
                id_next[8*item.sub +: 8] = id_reg[8*item.sub +: 8] | b;
            end
            CLS_PAYLOAD: begin
                crc_next = crc32_byte(crc_reg, b);
                if (!utf_reg.bad) begin
                    if (utf_reg.pending == 2'd0) begin
                        if (b <= LEAD_ASCII_MAX) begin
                            utf_next = utf_reg;
                        end else if (b >= LEAD_TWO_MIN && b <= LEAD_TWO_MAX) begin
                            utf_next.acc       = {16'h0000, b[4:0]};
                            utf_next.pending   = 2'd1;
                            utf_next.min_class = 2'd0;
                        end else if (b >= LEAD_THREE_MIN && b <= LEAD_THREE_MAX) begin
                            utf_next.acc       = {17'h00000, b[3:0]};
                            utf_next.pending   = 2'd2;
                            utf_next.min_class = 2'd1;
                        end else if (b >= LEAD_FOUR_MIN && b <= LEAD_FOUR_MAX) begin
                            utf_next.acc       = {18'h00000, b[2:0]};
                            utf_next.pending   = 2'd3;
                            utf_next.min_class = 2'd2;
                        end else begin
                            utf_next.bad = 1'b1;
                        end
                    end else if (b[7:6] != 2'b10) begin
                        utf_next.bad = 1'b1;
                    end else begin
                        utf_next.acc     = acc_sh;
                        utf_next.pending = utf_reg.pending - 2'd1;
                        if (utf_reg.pending == 2'd1) begin
                            if (acc_sh < cp_min || acc_sh > CP_MAX ||
                                (acc_sh >= CP_SURR_LO && acc_sh <= CP_SURR_HI)) begin
                                utf_next.bad = 1'b1;
                            end
                        end
                    end
                end
            end
            CLS_TRAILER: begin
                rx_crc_next = {b, rx_crc_reg[31:8]};
            end
            default: begin
                magic_ok_next = magic_ok_reg;
            end
        endcase
    end

    // Frame verdict
    always_comb begin
        len_bad = ({8'h00, max_len} < item.decl) ||
                  ({8'h00, item.total} != MIN_FRAME_BYTES + {1'b0, item.decl}) ||
                  utf_next.bad || (utf_next.pending != 2'd0);
        crc_bad = ((crc_next ^ CRC_INIT) != rx_crc_next);
        has_id  = (item.total >= HEADER_BYTES);
        if ({8'h00, item.total} < MIN_FRAME_BYTES) begin
            status = ST_BAD_LENGTH;
        end else if (!magic_ok_next) begin
            status = ST_BAD_MAGIC;
        end else if (!version_ok_next) begin
            status = ST_BAD_VERSION;
        end else if (len_bad) begin
            status = ST_BAD_LENGTH;
        end else if (crc_bad) begin
            status = ST_BAD_CRC;
        end else begin
            status = ST_ACCEPTED;
        end
    end

    // Result beat: payload_byte, payload_index, status, has_message_id,
    // message_id, payload_length from bit 0 up
    always_comb begin
        out_data_next = '0;
        if (item.last) begin
            out_kind_next        = KIND_VERDICT;
            out_data_next[18:16] = status;
            out_data_next[19]    = has_id;
            out_data_next[51:20] = has_id ? id_next : 32'h0000_0000;
            out_data_next[59:52] = (status == ST_ACCEPTED) ? item.decl[7:0] : 8'h00;
        end else begin
            out_kind_next        = KIND_PAYLOAD;
            out_data_next[7:0]   = b;
            out_data_next[15:8]  = item.pidx;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            magic_ok_reg   <= 1'b1;
            version_ok_reg <= 1'b1;
            id_reg         <= '0;
            crc_reg        <= CRC_INIT;
            rx_crc_reg     <= '0;
            utf_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (item_pop) begin
                if (item.last) begin
                    magic_ok_reg   <= 1'b1;
                    version_ok_reg <= 1'b1;
                    id_reg         <= '0;
                    crc_reg        <= CRC_INIT;
                    rx_crc_reg     <= '0;
                    utf_reg        <= '0;
                end else begin
                    magic_ok_reg   <= magic_ok_next;
                    version_ok_reg <= version_ok_next;
                    id_reg         <= id_next;
                    crc_reg        <= crc_next;
                    rx_crc_reg     <= rx_crc_next;
                    utf_reg        <= utf_next;
                end
            end
            if (slot_free) begin
                out_valid_reg <= item_pop && produce;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (slot_free) begin
            out_data_reg <= out_data_next;
            out_kind_reg <= out_kind_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_kind_reg;

endmodule

### rtl/crc_checked_frame_decoder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CRC-checked framed message decoder
// Takes a frame one byte a beat, passes payload bytes out and ends each frame
// with one verdict beat (magic, version, length, UTF-8 and CRC-32 checks).
// Sustains one byte per clock unless the result channel stalls: the front
// end tags each byte with its role in the frame, a FIFO_DEPTH-entry queue
// decouples it from the back end, and the back end folds one byte per cycle
// through an unrolled eight-bit CRC-32 step and the UTF-8 checker. Results
// leave through an output register. No clearing pass after reset.
// ----------------------------------------------------------------------------
module crc_checked_frame_decoder_top import ccfd_pkg::*; #(
    parameter int FIFO_DEPTH = 4
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,  // data_byte
    input  logic                  s_axis_tlast,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // payload_byte[7:0], payload_index[15:8], status[18:16],
    // has_message_id[19], message_id[51:20], payload_length[59:52], zero pad
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    output logic                  m_axis_tuser,  // kind
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [7:0]            cfg_data       // max_payload_len
);

    logic       cfg_write;
    logic [7:0] max_len_q_reg;
    logic       push_valid, push_ready, pop_valid, pop_ready;
    ccfd_item_t push_item, pop_item;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_len_q_reg <= 8'hFF;
        end else if (cfg_write) begin
            max_len_q_reg <= cfg_data;
        end
    end

    ccfd_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .push_valid    (push_valid),
        .push_ready    (push_ready),
        .push_item     (push_item)
    );

    ccfd_queue #(
        .DEPTH (FIFO_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    ccfd_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .max_len       (max_len_q_reg),
        .item_valid    (pop_valid),
        .item_pop      (pop_ready),
        .item          (pop_item),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

### rtl/ccfd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Decoder port checker
// Watches the result channel for well-formed payload and verdict beats.
// ----------------------------------------------------------------------------
`include "crc_checked_frame_decoder_top_defines.svh"

module ccfd_checker import ccfd_pkg::*; (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata,
    input logic                  m_axis_tuser
);

    logic payload_beat, verdict_beat, stalled;

    assign payload_beat = m_axis_tvalid && (m_axis_tuser == KIND_PAYLOAD);
    assign verdict_beat = m_axis_tvalid && (m_axis_tuser == KIND_VERDICT);
    assign stalled      = m_axis_tvalid && !m_axis_tready;

    `CCFD_ASSERT_NEXT(a_hold_stalled, aclk, aresetn, stalled,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    `CCFD_ASSERT_IMPLY(a_payload_clean, aclk, aresetn, payload_beat,
        m_axis_tdata[OUT_DATA_W-1:16] == '0)
    `CCFD_ASSERT_IMPLY(a_verdict_clean, aclk, aresetn, verdict_beat,
        m_axis_tdata[15:0] == 16'h0000 && m_axis_tdata[18:16] <= ST_BAD_CRC)
    `CCFD_ASSERT_IMPLY(a_length_only_ok, aclk, aresetn,
        verdict_beat && m_axis_tdata[18:16] != ST_ACCEPTED, m_axis_tdata[59:52] == 8'h00)
    `CCFD_ASSERT_IMPLY(a_id_needs_header, aclk, aresetn, verdict_beat && !m_axis_tdata[19],
        m_axis_tdata[51:20] == 32'h0000_0000 && m_axis_tdata[18:16] == ST_BAD_LENGTH)

endmodule

bind crc_checked_frame_decoder_top ccfd_checker u_ccfd_checker (.*);
